// File: hw/rtl/vn3_pkg.sv
`default_nettype none
package vn3_pkg;

  localparam int VecW  = 32;
  localparam int SumW  = 64;
  localparam int RootW = 32;
  localparam int QuotW = 31;
  localparam int RemW  = 62;

  localparam logic [QuotW-1:0] UNIT_ONE = 31'h4000_0000;

  // per-item flags that ride alongside the arithmetic
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic neg_z;
    logic zero;
  } side_t;

  function automatic logic [VecW-1:0] abs32(input logic [VecW-1:0] v);
    abs32 = v[VecW-1] ? (~v + 32'd1) : v;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/vector_normalize_3d_unit.sv
`default_nettype none
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | vec_x, vec_y, vec_z
// out     | out_valid | out_stall | unit_x, unit_y, unit_z, magnitude, zero_vector
//
// one item enters per cycle while in_stall is low; the pipeline holds the 32-stage
// bit-per-stage square root and the 31-stage restoring dividers
// rst clears the valid bits only; payload registers are not reset
// a stalled result freezes the whole pipeline; in_stall rises only while
// the output register holds an item and out_stall is high
module vector_normalize_3d_unit import vn3_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic signed [VecW-1:0] vec_x,
  input  wire logic signed [VecW-1:0] vec_y,
  input  wire logic signed [VecW-1:0] vec_z,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic signed [VecW-1:0]      unit_x,
  output logic signed [VecW-1:0]      unit_y,
  output logic signed [VecW-1:0]      unit_z,
  output logic        [RootW-1:0]     magnitude,
  output logic                        zero_vector
);

  // stage map: 0 input regs, 1-2 squares and sum, 3-34 root, 35-65 divide, 66 output
  localparam int NStg    = 67;
  localparam int MagDly  = 34;
  localparam int LenDly  = 31;
  localparam int SideDly = 65;

  logic [NStg-1:0] v;
  logic            adv;

  assign adv      = ~(v[NStg-1] & out_stall);
  assign in_stall = ~adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NStg-2:0], in_valid};
    end
  end

  // input register: magnitudes, signs, zero flag
  logic [VecW-1:0] mx_d [0:MagDly];
  logic [VecW-1:0] my_d [0:MagDly];
  logic [VecW-1:0] mz_d [0:MagDly];
  side_t           side_d [0:SideDly];

  always_ff @(posedge clk) begin
    if (adv) begin
      mx_d[0]        <= abs32(vec_x);
      my_d[0]        <= abs32(vec_y);
      mz_d[0]        <= abs32(vec_z);
      side_d[0].neg_x <= vec_x[VecW-1];
      side_d[0].neg_y <= vec_y[VecW-1];
      side_d[0].neg_z <= vec_z[VecW-1];
      side_d[0].zero  <= (vec_x == '0) && (vec_y == '0) && (vec_z == '0);
      for (int k = 0; k < MagDly; k++) begin
        mx_d[k+1] <= mx_d[k];
        my_d[k+1] <= my_d[k];
        mz_d[k+1] <= mz_d[k];
      end
      for (int k = 0; k < SideDly; k++) begin
        side_d[k+1] <= side_d[k];
      end
    end
  end

  logic [SumW-1:0]  sum;
  logic [RootW-1:0] len;

  vn3_square u_square (
    .clk(clk), .en(adv), .mag_x(mx_d[0]), .mag_y(my_d[0]), .mag_z(mz_d[0]), .sum(sum)
  );

  vn3_sqrt u_sqrt (.clk(clk), .en(adv), .n_in(sum), .root(len));

  // length rides along the dividers
  logic [RootW-1:0] len_d [0:LenDly];
  assign len_d[0] = len;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < LenDly; k++) begin
        len_d[k+1] <= len_d[k];
      end
    end
  end

  logic [QuotW-1:0] qx, qy, qz;

  vn3_div u_div_x (.clk(clk), .en(adv), .mag(mx_d[MagDly]), .len(len), .quo(qx));
  vn3_div u_div_y (.clk(clk), .en(adv), .mag(my_d[MagDly]), .len(len), .quo(qy));
  vn3_div u_div_z (.clk(clk), .en(adv), .mag(mz_d[MagDly]), .len(len), .quo(qz));

  // saturate, restore sign, force zeros for the zero vector
  function automatic logic [VecW-1:0] finish(input logic [QuotW-1:0] q,
                                             input logic neg, input logic zero);
    logic [QuotW-1:0] s;
    logic [VecW-1:0]  e;
    s = (q > UNIT_ONE) ? UNIT_ONE : q;
    e = {1'b0, s};
    if (zero) begin
      finish = '0;
    end else if (neg) begin
      finish = ~e + 32'd1;
    end else begin
      finish = e;
    end
  endfunction

  side_t sd;
  assign sd = side_d[SideDly];

  always_ff @(posedge clk) begin
    if (adv) begin
      unit_x      <= finish(qx, sd.neg_x, sd.zero);
      unit_y      <= finish(qy, sd.neg_y, sd.zero);
      unit_z      <= finish(qz, sd.neg_z, sd.zero);
      magnitude   <= sd.zero ? '0 : len_d[LenDly];
      zero_vector <= sd.zero;
    end
  end

  assign out_valid = v[NStg-1];

endmodule
`default_nettype wire

// File: hw/rtl/vn3_square.sv
`default_nettype none
module vn3_square import vn3_pkg::*; (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [VecW-1:0] mag_x,
  input  wire logic [VecW-1:0] mag_y,
  input  wire logic [VecW-1:0] mag_z,
  output logic      [SumW-1:0] sum
);

  logic [SumW-1:0] px, py, pz;

  // one 32x32 product per component, then the three-way sum
  always_ff @(posedge clk) begin
    if (en) begin
      px  <= {32'd0, mag_x} * {32'd0, mag_x};
      py  <= {32'd0, mag_y} * {32'd0, mag_y};
      pz  <= {32'd0, mag_z} * {32'd0, mag_z};
      sum <= px + py + pz;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/vn3_sqrt.sv
`default_nettype none
module vn3_sqrt import vn3_pkg::*; (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [SumW-1:0]  n_in,
  output logic      [RootW-1:0] root
);

  logic [SumW-1:0]  n_s    [0:RootW-1];
  logic [RootW-1:0] root_s [0:RootW];
  logic [SumW-1:0]  sq_s   [0:RootW-1];

  assign n_s[0]    = n_in;
  assign root_s[0] = '0;
  assign sq_s[0]   = '0;

  // one root bit per stage; root squared kept alongside to avoid a multiplier
  for (genvar k = 0; k < RootW; k++) begin : g_stage
    localparam int B = RootW - 1 - k;
    logic [SumW-1:0] trial_sq;
    logic            take;
    assign trial_sq = sq_s[k] + ({32'd0, root_s[k]} << (B + 1)) + (64'd1 << (2 * B));
    assign take     = (trial_sq <= n_s[k]);
    always_ff @(posedge clk) begin
      if (en) begin
        root_s[k+1] <= take ? (root_s[k] | (32'd1 << B)) : root_s[k];
      end
    end
    // the last stage only needs the root
    if (k < RootW - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          n_s[k+1]  <= n_s[k];
          sq_s[k+1] <= take ? trial_sq : sq_s[k];
        end
      end
    end
  end

  assign root = root_s[RootW];

endmodule
`default_nettype wire

// File: hw/rtl/vn3_div.sv
`default_nettype none
module vn3_div import vn3_pkg::*; (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [VecW-1:0]  mag,
  input  wire logic [RootW-1:0] len,
  output logic      [QuotW-1:0] quo
);

  logic [RemW-1:0]  rem_s [0:QuotW-1];
  logic [RootW-1:0] dv_s  [0:QuotW-1];
  logic [QuotW-1:0] q_s   [0:QuotW];

  assign rem_s[0] = {mag, 30'd0};
  assign dv_s[0]  = len;
  assign q_s[0]   = '0;

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < QuotW; k++) begin : g_stage
    localparam int I = QuotW - 1 - k;
    logic [RemW-1:0] shifted;
    logic            take;
    assign shifted = {30'd0, dv_s[k]} << I;
    assign take    = (rem_s[k] >= shifted);
    always_ff @(posedge clk) begin
      if (en) begin
        q_s[k+1] <= take ? (q_s[k] | (31'd1 << I)) : q_s[k];
      end
    end
    // the last stage only needs the quotient
    if (k < QuotW - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          dv_s[k+1]  <= dv_s[k];
          rem_s[k+1] <= take ? (rem_s[k] - shifted) : rem_s[k];
        end
      end
    end
  end

  assign quo = q_s[QuotW];

endmodule
`default_nettype wire
